// ===== hw/rtl/ate_pkg.sv =====
// Shared types and codes for the alarm table with expiry.
// Holds request and status codes, the entry record and the cell command.
// No dependencies.
package ate_pkg;

  localparam logic [2:0] REQ_ADD_ABS = 3'd0;
  localparam logic [2:0] REQ_ADD_REL = 3'd1;
  localparam logic [2:0] REQ_EXPIRE  = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UPDATED   = 2'd1;
  localparam logic [1:0] STAT_EVICTED   = 2'd2;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] t_start;
    logic [31:0] t_end;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_UPDATE,
    OP_APPEND,
    OP_COMPACT
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    entry_t      ent;
    logic [31:0] now;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_EXPIRE,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/ate_cell.sv =====
// One table cell: holds a single alarm entry and trades it with its neighbour.
// Depends on ate_pkg for the entry record and the cell command.
module ate_cell import ate_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [CW-1:0] count,
  input  entry_t        nbr,
  input  logic          prefix_in,
  output entry_t        ent,
  output logic          match,
  output logic          prefix_out
);

  entry_t ent_next;
  logic   valid;
  logic   drop;

  assign valid      = (CW'(IDX) < count);
  assign match      = valid && (ent.id == cmd.ent.id);
  assign drop       = valid && (ent.t_end < cmd.now);
  // a drop here or below pulls this cell and all above it down by one
  assign prefix_out = prefix_in | drop;

  always_comb begin
    ent_next = ent;
    case (cmd.op)
      OP_HOLD: ;
      OP_SHIFT: ent_next = nbr;
      OP_UPDATE: begin
        if (match) begin
          ent_next.t_start = cmd.ent.t_start;
          ent_next.t_end   = cmd.ent.t_end;
        end
      end
      OP_APPEND: begin
        if (count == CW'(IDX)) begin
          ent_next = cmd.ent;
        end
      end
      OP_COMPACT: begin
        if (prefix_out) begin
          ent_next = nbr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ===== hw/rtl/alarm_table_with_expiry.sv =====
// Top level of the alarm table with expiry: request decode, sequencer and
// the row of table cells. Depends on ate_pkg and ate_cell.
//
// Usage: one request word enters on the s_ side, one result word leaves on
// the m_ side for every request. The table is a row of TABLE_DEPTH cells,
// oldest entry in cell 0; each cell compares its own entry against the
// request and can take its upper neighbour's entry.
// Work done by the sequencer for each request before its result:
//   add (absolute or relative): a single compare-and-write in the row
//   expire: one compaction shift per removed entry
//   read in range: the row rotates once round, cell 0 is sampled at the
//     requested position
//   read out of range, clear, unused codes: straight to the result
// One request is in flight at a time; s_tready is high only while idle.
// A finished result sits in the output register; the next request is taken
// while it waits, and a further result holds in the sequencer until the
// receiver takes the previous one, so a stalled m_tready simply stalls.
// Reset empties the table (count to zero) and drops any pending result;
// entry contents are left as they were and are never seen past the count.
module alarm_table_with_expiry import ate_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // alarm_id, start_time, end_time, now_time, duration, entry_index, zero pad
  input  logic [151:0] s_tdata,
  // req_type
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_count, read_id, read_start, read_end, status, removed_count, zero pad
  output logic [95:0]  m_tdata
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int SW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMPW = (SW > 4) ? SW : 4;
  localparam int IW   = (CW > 4) ? CW : 4;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;

  // request held for the length of its work
  logic [2:0]    req;
  entry_t        r_ent;
  logic [31:0]   r_now;
  logic [3:0]    r_idx;
  logic [SW-1:0] step;

  // result under construction
  logic [15:0]   res_id;
  logic [31:0]   res_st;
  logic [31:0]   res_en;
  logic [1:0]    res_status;
  logic [CW-1:0] res_removed;

  // incoming word fields
  logic [15:0]   in_id;
  logic [31:0]   in_start;
  logic [31:0]   in_end;
  logic [31:0]   in_now;
  logic [31:0]   in_dur;
  logic [3:0]    in_idx;
  logic [32:0]   rel_sum;
  logic [31:0]   rel_end;
  logic          accept;
  logic          idx_ok;

  // row of cells
  cell_cmd_t        cmd;
  entry_t           ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] prefix;
  entry_t           tail_in;
  logic             tail_new;
  logic             match_any;
  logic             drop_any;
  logic             full;
  logic             out_load;
  logic             step_hit;
  logic             step_last;

  assign in_id    = s_tdata[15:0];
  assign in_start = s_tdata[47:16];
  assign in_end   = s_tdata[79:48];
  assign in_now   = s_tdata[111:80];
  assign in_dur   = s_tdata[143:112];
  assign in_idx   = s_tdata[147:144];

  // relative add: end saturates at the top of the range
  assign rel_sum = {1'b0, in_now} + {1'b0, in_dur};
  assign rel_end = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];

  assign accept    = s_tvalid && s_tready;
  assign idx_ok    = (IW'(in_idx) < IW'(count));
  assign match_any = |match;
  assign drop_any  = prefix[TABLE_DEPTH-1];
  assign full      = (count == CW'(TABLE_DEPTH));
  assign step_hit  = (CMPW'(step) == CMPW'(r_idx));
  assign step_last = (step == SW'(TABLE_DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (s_tuser) inside
            REQ_ADD_ABS, REQ_ADD_REL: state_next = S_ADD;
            REQ_EXPIRE:               state_next = S_EXPIRE;
            REQ_READ:                 state_next = idx_ok ? S_READ : S_DONE;
            default:                  state_next = S_DONE;
          endcase
        end
      end
      S_ADD:    state_next = S_DONE;
      S_EXPIRE: state_next = drop_any ? S_EXPIRE : S_DONE;
      S_READ:   state_next = step_last ? S_DONE : S_READ;
      S_DONE:   state_next = (!m_tvalid || m_tready) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    cmd.op   = OP_HOLD;
    cmd.ent  = r_ent;
    cmd.now  = r_now;
    tail_new = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_ADD: begin
        if (match_any) begin
          cmd.op = OP_UPDATE;
        end else if (full) begin
          // evict: slide everything down, new entry enters the top cell
          cmd.op   = OP_SHIFT;
          tail_new = 1'b1;
        end else begin
          cmd.op = OP_APPEND;
        end
      end
      S_EXPIRE: cmd.op = drop_any ? OP_COMPACT : OP_HOLD;
      S_READ:   cmd.op = OP_SHIFT;
      S_DONE:   out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // rotate cell 0 back round to the top unless a new entry goes in
  assign tail_in = tail_new ? r_ent : ent[0];

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      entry_t nbr;
      logic   pin;
      if (gi == TABLE_DEPTH - 1) begin : g_top
        assign nbr = tail_in;
      end else begin : g_mid
        assign nbr = ent[gi+1];
      end
      if (gi == 0) begin : g_first
        assign pin = 1'b0;
      end else begin : g_rest
        assign pin = prefix[gi-1];
      end
      ate_cell #(
        .IDX (gi),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .count      (count),
        .nbr        (nbr),
        .prefix_in  (pin),
        .ent        (ent[gi]),
        .match      (match[gi]),
        .prefix_out (prefix[gi])
      );
    end
  endgenerate

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && s_tuser == REQ_CLEAR) begin
        count <= '0;
      end
      if (state == S_ADD && !match_any && !full) begin
        count <= count + CW'(1);
      end
      if (state == S_EXPIRE && drop_any) begin
        count <= count - CW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req             <= s_tuser;
      r_ent.id        <= in_id;
      r_ent.t_start   <= (s_tuser == REQ_ADD_REL) ? in_now : in_start;
      r_ent.t_end     <= (s_tuser == REQ_ADD_REL) ? rel_end : in_end;
      r_now           <= in_now;
      r_idx           <= in_idx;
      step            <= '0;
      res_id          <= '0;
      res_st          <= '0;
      res_en          <= '0;
      res_status      <= (s_tuser == REQ_READ && !idx_ok) ? STAT_BAD_INDEX : STAT_OK;
      res_removed     <= (s_tuser == REQ_CLEAR) ? count : '0;
    end
    if (state == S_ADD) begin
      if (match_any) begin
        res_status <= STAT_UPDATED;
      end else if (full) begin
        res_status <= STAT_EVICTED;
      end
    end
    if (state == S_EXPIRE && drop_any) begin
      res_removed <= res_removed + CW'(1);
    end
    if (state == S_READ) begin
      step <= step + SW'(1);
      // cell 0 holds the entry at position step during the rotation
      if (step_hit && req == REQ_READ) begin
        res_id <= ent[0].id;
        res_st <= ent[0].t_start;
        res_en <= ent[0].t_end;
      end
    end
    if (out_load) begin
      m_tdata <= {4'b0000, 5'(res_removed), res_status, res_en, res_st, res_id,
                  5'(count)};
    end
  end

endmodule
